/* design/les_pkg.sv */
// Package for the lamp effect sequencer: item codes and the effect pattern ROM.
package les_pkg;

   // Item kinds carried in the request tuser field
   typedef enum logic [1:0] {
      MODE_POST  = 2'd0,
      MODE_POLL  = 2'd1,
      MODE_TICK  = 2'd2,
      MODE_SPARE = 2'd3
   } mode_type;

   localparam int NUM_PATTERNS = 7;
   localparam int PAT_W        = 3;
   localparam int POS_W        = 3;
   localparam int TMR_W        = 8;
   localparam int LAMP_W       = 2;

   localparam logic [TMR_W-1:0] RESET_HOLD = 8'd10;

   // Pattern codes
   localparam logic [PAT_W-1:0] PAT_DARK   = 3'd0;
   localparam logic [PAT_W-1:0] PAT_LIGHT  = 3'd1;
   localparam logic [PAT_W-1:0] PAT_SHORT  = 3'd2;
   localparam logic [PAT_W-1:0] PAT_BLINK1 = 3'd3;
   localparam logic [PAT_W-1:0] PAT_BLINK2 = 3'd4;
   localparam logic [PAT_W-1:0] PAT_BLINK3 = 3'd5;
   localparam logic [PAT_W-1:0] PAT_BLINK4 = 3'd6;

   // Out-of-range pattern codes play as dark
   function automatic logic [PAT_W-1:0] pat_norm(input logic [PAT_W-1:0] p);
      return (p >= PAT_W'(NUM_PATTERNS)) ? PAT_DARK : p;
   endfunction

   // Number of entries in a pattern
   function automatic logic [POS_W-1:0] pat_len(input logic [PAT_W-1:0] p);
      logic [POS_W-1:0] n;
      case (p)
         PAT_DARK, PAT_LIGHT: n = 3'd1;
         PAT_BLINK2:          n = 3'd6;
         default:             n = 3'd2;
      endcase
      return n;
   endfunction

   // Pattern loops back to its first entry at its end
   function automatic logic pat_loops(input logic [PAT_W-1:0] p);
      return (p >= PAT_BLINK1) && (p <= PAT_BLINK4);
   endfunction

   // Entry position past the pattern end reads as the first entry
   function automatic logic [POS_W-1:0] pos_norm(input logic [PAT_W-1:0] p,
                                                 input logic [POS_W-1:0] pos);
      return (pos >= pat_len(p)) ? '0 : pos;
   endfunction

   // Lamp level of an entry: even entries on, odd off, dark pattern always off
   function automatic logic pat_level(input logic [PAT_W-1:0] p,
                                      input logic [POS_W-1:0] pos);
      return (p != PAT_DARK) && !pos[0];
   endfunction

   // Hold duration of an entry, in ticks
   function automatic logic [TMR_W-1:0] pat_dur(input logic [PAT_W-1:0] p,
                                                input logic [POS_W-1:0] pos);
      logic [TMR_W-1:0] d;
      case (p)
         PAT_BLINK2: d = (pos == 3'd5) ? 8'd200 : 8'd10;
         PAT_BLINK3: d = 8'd30;
         PAT_BLINK4: d = 8'd50;
         default:    d = 8'd10;
      endcase
      return d;
   endfunction

endpackage

/* design/led_effect_sequencer.sv */
// Top level of the lamp effect sequencer: per-channel queues, sequencer and pattern player.
//
//  Channel  Direction  tdata (low bit up)                    tuser
//  req_     in         channel[1:0] effect[4:2] clear[5]     mode[1:0]
//  rsp_     out        lamp_on[1:0] rejected[2]              -
//
// A post goes through ST_POST to ST_EMIT (straight to ST_EMIT when the channel is out of
// range); a poll visits every channel in ST_POLL_RD, with ST_POLL_LD for each channel that loads an
// effect (queue memory read is registered); a tick visits every channel in ST_TICK, one
// channel a cycle through the shared timer/entry update. An unused mode goes straight to ST_EMIT.
// Reset (synchronous, active high) clears all channels to the dark pattern with the
// hold timer at ten and empties every queue; the queue memory is not cleared.
// The result register is separate from the sequencer: a new item is taken while a
// result waits, and the sequencer holds its finished result until rsp_ is free.
module led_effect_sequencer #(
   parameter int CHANNELS    = 2,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // channel[1:0], effect[4:2], clear[5]
   input  logic [1:0] req_tuser,   // mode[1:0]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // lamp_on[1:0], rejected[2]
);
   import les_pkg::*;

   localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int HW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = ((HW > CNT_W) ? HW : CNT_W) + 1;
   localparam int SLOTS  = CHANNELS * QUEUE_DEPTH;
   localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LAMP_N = (CHANNELS < LAMP_W) ? CHANNELS : LAMP_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POST,
      ST_POLL_RD,
      ST_POLL_LD,
      ST_TICK,
      ST_EMIT
   } state_type;

   // Sequencer and per-channel state
   state_type            state_ff, state_in;
   logic [CW-1:0]        ch_ff, ch_in;
   logic [PAT_W-1:0]     effect_ff, effect_in;
   logic                 clear_ff, clear_in;
   logic                 rej_ff, rej_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LAMP_W-1:0]    rsp_lamp_ff, rsp_lamp_in;
   logic                 rsp_rej_ff, rsp_rej_in;

   logic [PAT_W-1:0]     pat_ff  [CHANNELS], pat_in  [CHANNELS];
   logic [POS_W-1:0]     pos_ff  [CHANNELS], pos_in  [CHANNELS];
   logic [TMR_W-1:0]     tmr_ff  [CHANNELS], tmr_in  [CHANNELS];
   logic                 busy_ff [CHANNELS], busy_in [CHANNELS];
   logic [CNT_W-1:0]     cnt_ff  [CHANNELS], cnt_in  [CHANNELS];
   logic [HW-1:0]        head_ff [CHANNELS], head_in [CHANNELS];

   // Queue memory
   logic [PAT_W-1:0]     queue_mem [SLOTS];
   logic [PAT_W-1:0]     mem_rd_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [AW-1:0]        mem_raddr;

   logic [LAMP_W-1:0]    lamp;
   logic                 last_ch;
   logic [AW-1:0]        ch_base;

   mode_type             req_mode;
   logic [1:0]           req_chan;

   assign req_mode   = mode_type'(req_tuser);
   assign req_chan   = req_tdata[1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_rej_ff, rsp_lamp_ff};

   assign last_ch    = (ch_ff == CW'(CHANNELS - 1));
   assign ch_base    = AW'(ch_ff) * AW'(QUEUE_DEPTH);
   assign mem_raddr  = ch_base + AW'(head_ff[ch_ff]);

   // Lamp levels of the first two channels
   always_comb begin
      lamp = '0;
      for (int i = 0; i < LAMP_N; i++) begin
         lamp[i] = pat_level(pat_norm(pat_ff[i]), pos_norm(pat_norm(pat_ff[i]), pos_ff[i]));
      end
   end

   // Next-state logic: one channel visited per cycle; a poll that loads holds its channel for ST_POLL_LD
   always_comb begin
      logic [CNT_W-1:0] cnt_eff;
      logic [HW-1:0]    head_eff;
      logic [SUM_W-1:0] tail_sum;
      logic [HW:0]      head_inc;
      logic [PAT_W-1:0] tp;
      logic [POS_W-1:0] tpos;
      logic [TMR_W-1:0] tt;

      state_in     = state_ff;
      ch_in        = ch_ff;
      effect_in    = effect_ff;
      clear_in     = clear_ff;
      rej_in       = rej_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_lamp_in  = rsp_lamp_ff;
      rsp_rej_in   = rsp_rej_ff;
      pat_in       = pat_ff;
      pos_in       = pos_ff;
      tmr_in       = tmr_ff;
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      mem_we       = 1'b0;

      cnt_eff  = clear_ff ? '0 : cnt_ff[ch_ff];
      head_eff = clear_ff ? '0 : head_ff[ch_ff];
      tail_sum = SUM_W'(head_eff) + SUM_W'(cnt_eff);
      if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
      end
      mem_waddr = ch_base + AW'(tail_sum[HW-1:0]);

      head_inc = {1'b0, head_ff[ch_ff]} + 1'b1;
      if (head_inc == (HW + 1)'(QUEUE_DEPTH)) begin
         head_inc = '0;
      end

      tp   = pat_norm(pat_ff[ch_ff]);
      tpos = pos_norm(tp, pos_ff[ch_ff]);
      tt   = (tmr_ff[ch_ff] != '0) ? tmr_ff[ch_ff] - 1'b1 : '0;

      // Result register drains independently of the sequencer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               effect_in = req_tdata[4:2];
               clear_in  = req_tdata[5];
               rej_in    = 1'b0;
               ch_in     = '0;
               unique case (req_mode)
                  MODE_POST: begin
                     if (32'(req_chan) >= CHANNELS) begin
                        rej_in   = 1'b1;
                        state_in = ST_EMIT;
                     end else begin
                        ch_in    = CW'(req_chan);
                        state_in = ST_POST;
                     end
                  end
                  MODE_POLL: state_in = ST_POLL_RD;
                  MODE_TICK: state_in = ST_TICK;
                  default:   state_in = ST_EMIT;
               endcase
            end
         end

         // Optional clear, then enqueue at the tail or drop when full
         ST_POST: begin
            if (clear_ff) begin
               busy_in[ch_ff] = 1'b0;
            end
            cnt_in[ch_ff]  = cnt_eff;
            head_in[ch_ff] = head_eff;
            if (cnt_eff >= CNT_W'(QUEUE_DEPTH)) begin
               rej_in = 1'b1;
            end else begin
               mem_we        = 1'b1;
               cnt_in[ch_ff] = cnt_eff + 1'b1;
            end
            state_in = ST_EMIT;
         end

         // Idle channel with a queued code: head slot read is under way
         ST_POLL_RD: begin
            if ((cnt_ff[ch_ff] != '0) && !busy_ff[ch_ff]) begin
               state_in = ST_POLL_LD;
            end else if (last_ch) begin
               state_in = ST_EMIT;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end

         // Pop the head code and start its pattern (an unknown code only marks the channel busy)
         ST_POLL_LD: begin
            head_in[ch_ff] = head_inc[HW-1:0];
            cnt_in[ch_ff]  = cnt_ff[ch_ff] - 1'b1;
            busy_in[ch_ff] = 1'b1;
            if (mem_rd_ff < PAT_W'(NUM_PATTERNS)) begin
               pat_in[ch_ff] = mem_rd_ff;
               pos_in[ch_ff] = '0;
               tmr_in[ch_ff] = pat_dur(mem_rd_ff, '0);
            end
            if (last_ch) begin
               state_in = ST_EMIT;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_POLL_RD;
            end
         end

         // Count the hold timer down; at zero advance, loop or finish
         ST_TICK: begin
            tmr_in[ch_ff] = tt;
            if (tt == '0) begin
               if ((tpos + 1'b1) >= pat_len(tp)) begin
                  if (!pat_loops(tp)) begin
                     busy_in[ch_ff] = 1'b0;
                  end else begin
                     pos_in[ch_ff] = '0;
                     tmr_in[ch_ff] = pat_dur(tp, '0);
                  end
               end else begin
                  pos_in[ch_ff] = tpos + 1'b1;
                  tmr_in[ch_ff] = pat_dur(tp, tpos + 1'b1);
               end
            end
            if (last_ch) begin
               state_in = ST_EMIT;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end

         // Hand the result over once the result register is free
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_lamp_in  = lamp;
               rsp_rej_in   = rej_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         rej_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            pat_ff[i]  <= PAT_DARK;
            pos_ff[i]  <= '0;
            tmr_ff[i]  <= RESET_HOLD;
            busy_ff[i] <= 1'b0;
            cnt_ff[i]  <= '0;
            head_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rej_ff       <= rej_in;
         rsp_valid_ff <= rsp_valid_in;
         pat_ff       <= pat_in;
         pos_ff       <= pos_in;
         tmr_ff       <= tmr_in;
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
      end
      effect_ff   <= effect_in;
      clear_ff    <= clear_in;
      rsp_lamp_ff <= rsp_lamp_in;
      rsp_rej_ff  <= rsp_rej_in;
   end

   // Queue memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[mem_waddr] <= effect_ff;
      end
      mem_rd_ff <= queue_mem[mem_raddr];
   end

   // Checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      32'(head_ff[0]) < QUEUE_DEPTH)
      else $error("queue head out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while previous one in progress");

   a_load_needs_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POLL_LD) |-> ((cnt_ff[ch_ff] != '0) && !busy_ff[ch_ff]))
      else $error("load from empty queue or busy channel");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench for the lamp effect sequencer: stream stimulus checked item by item.
module tb;
   import les_pkg::*;

   localparam int NUM_CH      = 2;
   localparam int Q_DEPTH     = 4;
   localparam int FX_PATTERNS = 7;
   localparam int FX_ENTRIES  = 6;
   localparam logic [2:0] FX_UNKNOWN = 3'd7;
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 16;

   typedef struct {
      mode_type   mode;
      logic [1:0] channel;
      logic [2:0] effect;
      logic       clear;
   } lamp_cmd_type;

   typedef struct {
      logic [1:0] lamp_on;
      logic       rejected;
   } lamp_state_type;

   // Effect ROM: entry count, loop flag, level bit per entry, hold ticks per entry
   int unsigned fx_len [FX_PATTERNS] = '{1, 1, 2, 2, 6, 2, 2};
   logic fx_loops [FX_PATTERNS] = '{0, 0, 0, 1, 1, 1, 1};
   logic [FX_ENTRIES-1:0] fx_level [FX_PATTERNS] = '{
      6'b000000, 6'b000001, 6'b000001, 6'b000001, 6'b010101, 6'b000001, 6'b000001};
   logic [7:0] fx_hold [FX_PATTERNS][FX_ENTRIES] = '{
      '{10, 0, 0, 0, 0, 0},
      '{10, 0, 0, 0, 0, 0},
      '{10, 10, 0, 0, 0, 0},
      '{10, 10, 0, 0, 0, 0},
      '{10, 10, 10, 10, 10, 200},
      '{30, 30, 0, 0, 0, 0},
      '{50, 50, 0, 0, 0, 0}};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;   // channel[1:0], effect[4:2], clear[5]
   logic [1:0] req_tuser = '0;   // mode[1:0]
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;        // lamp_on[1:0], rejected[2]

   // Predicted channel state
   logic [2:0] ch_pat  [NUM_CH];
   logic [3:0] ch_pos  [NUM_CH];
   logic [7:0] ch_hold [NUM_CH];
   logic       ch_busy [NUM_CH];
   logic [2:0] q_slot  [NUM_CH][Q_DEPTH];
   logic [2:0] q_fill  [NUM_CH];
   logic [1:0] q_head  [NUM_CH];

   lamp_cmd_type   pending[$];
   lamp_state_type lamp_expect[$];
   lamp_cmd_type   cur_cmd;
   lamp_state_type want;
   logic        calm = 1'b0;
   int send_gap, recv_stall, idle_cycles;
   int n_queued, n_accepted, n_checked, n_fail;
   int n_post, n_drop, n_poll, n_load, n_tick, n_done, n_spare;

   always #2 clock = ~clock;

   led_effect_sequencer #(.CHANNELS(NUM_CH), .QUEUE_DEPTH(Q_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

   // Apply one item to the predicted state and return the lamp levels after it
   function automatic lamp_state_type lamp_predict(lamp_cmd_type cmd);
      lamp_state_type r;
      int p, pos, ch;
      logic [2:0] code;
      r.lamp_on  = 2'b00;
      r.rejected = 1'b0;
      case (cmd.mode)
         MODE_POST: begin
            n_post++;
            if (int'(cmd.channel) >= NUM_CH) begin
               r.rejected = 1'b1;
            end else begin
               ch = int'(cmd.channel);
               if (cmd.clear) begin
                  q_fill[ch]  = '0;
                  q_head[ch]  = '0;
                  ch_busy[ch] = 1'b0;
               end
               if (int'(q_fill[ch]) >= Q_DEPTH) begin
                  r.rejected = 1'b1;
               end else begin
                  q_slot[ch][(int'(q_head[ch]) + int'(q_fill[ch])) % Q_DEPTH] = cmd.effect;
                  q_fill[ch]++;
               end
            end
            if (r.rejected) n_drop++;
         end
         MODE_POLL: begin
            n_poll++;
            for (int i = 0; i < NUM_CH; i++) begin
               if (q_fill[i] != 0 && !ch_busy[i]) begin
                  code = q_slot[i][q_head[i]];
                  q_head[i]++;
                  q_fill[i]--;
                  ch_busy[i] = 1'b1;
                  n_load++;
                  // unknown code only marks the channel busy
                  if (int'(code) < FX_PATTERNS) begin
                     ch_pat[i]  = code;
                     ch_pos[i]  = '0;
                     ch_hold[i] = fx_hold[code][0];
                  end
               end
            end
         end
         MODE_TICK: begin
            n_tick++;
            for (int i = 0; i < NUM_CH; i++) begin
               p   = (int'(ch_pat[i]) < FX_PATTERNS) ? int'(ch_pat[i]) : 0;
               pos = (int'(ch_pos[i]) < fx_len[p]) ? int'(ch_pos[i]) : 0;
               if (ch_hold[i] != 0) ch_hold[i]--;
               if (ch_hold[i] == 0) begin
                  if (pos + 1 < fx_len[p] || fx_loops[p]) begin
                     pos = (pos + 1 < fx_len[p]) ? pos + 1 : 0;
                     ch_pos[i]  = 4'(pos);
                     ch_hold[i] = fx_hold[p][pos];
                  end else begin
                     // end marker: hold last entry, busy drops on every tick at zero
                     if (ch_busy[i]) n_done++;
                     ch_busy[i] = 1'b0;
                  end
               end
            end
         end
         default: n_spare++;
      endcase
      for (int i = 0; i < NUM_CH && i < 2; i++) begin
         p   = (int'(ch_pat[i]) < FX_PATTERNS) ? int'(ch_pat[i]) : 0;
         pos = (int'(ch_pos[i]) < fx_len[p]) ? int'(ch_pos[i]) : 0;
         r.lamp_on[i] = fx_level[p][pos];
      end
      return r;
   endfunction

   task automatic push_cmd(mode_type m, int ch, logic [2:0] fx, logic clr);
      lamp_cmd_type c;
      c.mode    = m;
      c.channel = 2'(ch);
      c.effect  = fx;
      c.clear   = clr;
      pending.push_back(c);
      n_queued++;
   endtask

   // Mostly ticks so patterns run their course; posts and polls keep queues moving
   task automatic push_random(int count);
      lamp_cmd_type c;
      int roll;
      for (int k = 0; k < count; k++) begin
         roll      = $urandom_range(0, 99);
         c.mode    = (roll < 25) ? MODE_POST : (roll < 37) ? MODE_POLL :
                     (roll < 97) ? MODE_TICK : MODE_SPARE;
         c.channel = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                 : 2'($urandom_range(0, 1));
         c.effect  = 3'($urandom_range(0, 7));
         c.clear   = ($urandom_range(0, 6) == 0);
         pending.push_back(c);
         n_queued++;
      end
   endtask

   task automatic wait_drained();
      while (n_accepted != n_queued || lamp_expect.size() != 0) @(posedge clock);
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            lamp_expect.push_back(lamp_predict(cur_cmd));
            n_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0 && !calm) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending.size() != 0) begin
               cur_cmd = pending.pop_front();
               req_tdata  <= {2'b00, cur_cmd.clear, cur_cmd.effect, cur_cmd.channel};
               req_tuser  <= cur_cmd.mode;
               req_tvalid <= 1'b1;
               if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 6);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_checked++;
            if (lamp_expect.size() == 0) begin
               $display("%0t: unexpected result, actual lamp_on %b rejected %b",
                        $time, rsp_tdata[1:0], rsp_tdata[2]);
               n_fail++;
            end else begin
               want = lamp_expect.pop_front();
               if (rsp_tdata[1:0] !== want.lamp_on) begin
                  $display("%0t: lamp_on mismatch, expected %b, actual %b",
                           $time, want.lamp_on, rsp_tdata[1:0]);
                  n_fail++;
               end
               if (rsp_tdata[2] !== want.rejected) begin
                  $display("%0t: rejected mismatch, expected %b, actual %b",
                           $time, want.rejected, rsp_tdata[2]);
                  n_fail++;
               end
            end
         end
         if (recv_stall != 0 && !calm) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) recv_stall = $urandom_range(1, 6);
         end
      end
   end

   // Watchdog: too long without any item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < NUM_CH; i++) begin
         ch_pat[i]  = PAT_DARK;
         ch_pos[i]  = '0;
         ch_hold[i] = RESET_HOLD;
         ch_busy[i] = 1'b0;
         q_fill[i]  = '0;
         q_head[i]  = '0;
      end

      // Directed: bad channels, full queue, unknown code, clear, spare mode
      push_cmd(MODE_TICK,  0, PAT_DARK,   1'b0);
      push_cmd(MODE_SPARE, 3, FX_UNKNOWN, 1'b1);
      push_cmd(MODE_POST,  2, FX_UNKNOWN, 1'b1);
      push_cmd(MODE_POST,  3, PAT_DARK,   1'b0);
      push_cmd(MODE_POST,  0, PAT_BLINK1, 1'b0);
      push_cmd(MODE_POST,  0, PAT_BLINK2, 1'b0);
      push_cmd(MODE_POST,  0, PAT_BLINK3, 1'b0);
      push_cmd(MODE_POST,  0, PAT_BLINK4, 1'b0);
      push_cmd(MODE_POST,  0, PAT_LIGHT,  1'b0);
      push_cmd(MODE_POST,  1, FX_UNKNOWN, 1'b0);
      push_cmd(MODE_POLL,  0, PAT_DARK,   1'b0);
      push_cmd(MODE_TICK,  0, PAT_DARK,   1'b0);
      push_cmd(MODE_POST,  1, PAT_SHORT,  1'b1);
      push_cmd(MODE_POLL,  0, PAT_DARK,   1'b0);
      push_cmd(MODE_POST,  0, PAT_DARK,   1'b1);
      push_cmd(MODE_POST,  0, PAT_LIGHT,  1'b0);
      push_cmd(MODE_POLL,  0, PAT_DARK,   1'b0);
      push_cmd(MODE_TICK,  0, PAT_DARK,   1'b0);
      push_cmd(MODE_POLL,  0, PAT_DARK,   1'b0);
      push_cmd(MODE_POST,  1, PAT_LIGHT,  1'b1);
      push_cmd(MODE_POLL,  0, PAT_DARK,   1'b0);
      push_cmd(MODE_TICK,  0, PAT_DARK,   1'b0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Random phases; the sender holds off until all results are back between them
      wait_drained();
      push_random(500);
      wait_drained();
      push_random(400);
      wait_drained();
      calm = 1'b1;
      push_random(100);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d posts (%0d dropped), %0d polls loading %0d effects,",
               n_post, n_drop, n_poll, n_load);
      $display("%0d ticks, %0d spare; %0d patterns ran to their end; %0d results, %0d mismatches",
               n_tick, n_spare, n_done, n_checked, n_fail);
      if (n_fail == 0 && lamp_expect.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
